[design/voxel_island_finder_top_macros.svh]
// assertion macros for the voxel island finder
// used by voxel_island_finder_top; expects clk and rst_n in scope
`ifndef VOXEL_ISLAND_FINDER_TOP_MACROS_SVH
`define VOXEL_ISLAND_FINDER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define VIF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vif check failed");
`define VIF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vif check failed");
`else
`define VIF_ASSERT_NOW(label, ante, cons)
`define VIF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[design/vif_pkg.sv]
// shared types, constants and helpers for the voxel island finder
// no dependencies
`default_nettype none
package vif_pkg;
  localparam int MAX_DIM = 16;
  localparam int CW = $clog2(MAX_DIM);
  localparam int AW = 3 * CW;
  localparam int CELLS = MAX_DIM * MAX_DIM * MAX_DIM;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_FETCH = 2'd2;

  localparam logic [1:0] CFG_SIZE_X = 2'd0;
  localparam logic [1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [1:0] CFG_SIZE_Z = 2'd2;

  typedef enum logic [3:0] {
    S_CLR_ALL, S_IDLE, S_CLR_VIS, S_SCAN_RD, S_SCAN_CK,
    S_POP_RD, S_POP_WT, S_NB_RD, S_NB_CK, S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    DIR_PX, DIR_MX, DIR_PY, DIR_MY, DIR_PZ, DIR_MZ
  } dir_t;

  typedef struct packed {
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_occ_en;
    logic          wr_occ_d;
    logic          wr_vis_en;
    logic          wr_vis_d;
  } cell_req_t;

  typedef struct packed {
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] wr_data;
    logic [AW-1:0] rd_addr;
  } queue_req_t;

  function automatic logic [4:0] vif_extent(input logic [4:0] v);
    if (v == 5'd0) return 5'd1;
    if (v > 5'(MAX_DIM)) return 5'(MAX_DIM);
    return v;
  endfunction
endpackage
`default_nettype wire

[design/vif_cell_mem.sv]
// occupancy and visited bit memories, one read port and one write port each
// depends on vif_pkg
`default_nettype none
module vif_cell_mem (
  input  wire logic              clk,
  input  wire vif_pkg::cell_req_t req,
  output logic                   rd_occ,
  output logic                   rd_vis
);
  import vif_pkg::*;

  logic occ_mem [CELLS];
  logic vis_mem [CELLS];

  always_ff @(posedge clk) begin
    if (req.wr_occ_en) begin
      occ_mem[req.wr_addr] <= req.wr_occ_d;
    end
    if (req.wr_vis_en) begin
      vis_mem[req.wr_addr] <= req.wr_vis_d;
    end
    rd_occ <= occ_mem[req.rd_addr];
    rd_vis <= vis_mem[req.rd_addr];
  end
endmodule
`default_nettype wire

[design/vif_queue_mem.sv]
// flood fill queue memory, cell addresses, one write and one read port
// depends on vif_pkg
`default_nettype none
module vif_queue_mem (
  input  wire logic                clk,
  input  wire vif_pkg::queue_req_t req,
  output logic [vif_pkg::AW-1:0]   rd_data
);
  import vif_pkg::*;

  logic [AW-1:0] q_mem [CELLS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      q_mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= q_mem[req.rd_addr];
  end
endmodule
`default_nettype wire

[design/voxel_island_finder_top.sv]
// voxel island finder: 6-connected flood fill labeling over a 16^3 grid
// depends on vif_pkg, vif_cell_mem, vif_queue_mem, voxel_island_finder_top_macros.svh
//
// usage: words on the in_ channel carry an opcode in in_tuser: write voxel,
// start traversal or fetch next voxel. a start sweeps the visited memory
// with in_tready low. after reset both cell memories are swept before the
// first word is taken.
// only a fetch returns a word on the out_ channel: the popped voxel and its
// island number, with out_tlast on the voxel that closes an island (bounds
// valid then) and out_tuser set when no island remains.
// a fetch pops from the queue (read, then wait), reads then checks each in-range
// neighbor (one port of the cell memories), skips each neighbor outside the
// grid and then emits the result. when the queue is
// empty the seed scan takes the place of the pop, reading then checking each
// cell walked; with no seed left the result follows the last cell walked.
// if out_tready is low the result waits in the output register and the next
// words are still taken; a later fetch holds in emit, in_tready low, until
// the register drains. cfg_ writes set size_x, size_y, size_z, always taken.
`default_nettype none
`include "voxel_island_finder_top_macros.svh"
module voxel_island_finder_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // coord_x, coord_y, coord_z, voxel_value, pad
  input  wire logic [1:0]  in_tuser,   // opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // out_x, out_y, out_z, island_number, min_x,
                                       // min_y, min_z, max_x, max_y, max_z, pad
  output logic             out_tlast,  // island_end
  output logic             out_tuser,  // all_done
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [4:0]  cfg_data
);
  import vif_pkg::*;

  state_t state_r, state_nxt;
  dir_t   dir_r, dir_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW:0]   sp_r, sp_nxt, head_r, head_nxt, tail_r, tail_nxt;
  logic [11:0]   cnt_r, cnt_nxt;
  logic [AW-1:0] cur_r, cur_nxt, sa_r, sa_nxt, na_r, na_nxt;
  logic [CW-1:0] lo_x_r, lo_y_r, lo_z_r, hi_x_r, hi_y_r, hi_z_r;
  logic [CW-1:0] lo_x_nxt, lo_y_nxt, lo_z_nxt, hi_x_nxt, hi_y_nxt, hi_z_nxt;
  logic          done_r, done_nxt;
  logic [4:0]    size_x_r, size_y_r, size_z_r;
  logic [4:0]    ex, ey, ez;

  logic          out_valid_r;
  logic [47:0]   out_data_r;
  logic          out_last_r, out_user_r;
  logic          emit_load;

  cell_req_t     creq;
  queue_req_t    qreq;
  logic          rd_occ, rd_vis;
  logic [AW-1:0] q_rd;

  logic          in_acc;
  logic [CW-1:0] wx, wy, wz;
  logic [CW-1:0] cx, cy, cz, sx, sy, sz, qx, qy, qz;
  logic [5:0]    nx, ny, nz;
  logic          nb_ok, sa_in, hit, cfg_acc;

  vif_cell_mem u_cell (.clk(clk), .req(creq), .rd_occ(rd_occ), .rd_vis(rd_vis));
  vif_queue_mem u_queue (.clk(clk), .req(qreq), .rd_data(q_rd));

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign ex = vif_extent(size_x_r);
  assign ey = vif_extent(size_y_r);
  assign ez = vif_extent(size_z_r);

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign wx = in_tdata[3:0];
  assign wy = in_tdata[7:4];
  assign wz = in_tdata[11:8];

  // cell address is {y, z, x}
  assign cx = cur_r[CW-1:0];
  assign cz = cur_r[2*CW-1:CW];
  assign cy = cur_r[AW-1:2*CW];
  assign sx = sa_r[CW-1:0];
  assign sz = sa_r[2*CW-1:CW];
  assign sy = sa_r[AW-1:2*CW];
  assign qx = q_rd[CW-1:0];
  assign qz = q_rd[2*CW-1:CW];
  assign qy = q_rd[AW-1:2*CW];

  assign sa_in = ({1'b0, sx} < ex) && ({1'b0, sy} < ey) && ({1'b0, sz} < ez);
  assign hit   = rd_occ && !rd_vis;
  assign emit_load = (state_r == S_EMIT) && (!out_valid_r || out_tready);

  // neighbor of the current voxel in the current direction
  always_comb begin
    nx = {2'b00, cx};
    ny = {2'b00, cy};
    nz = {2'b00, cz};
    unique case (dir_r)
      DIR_PX:  nx = {2'b00, cx} + 6'd1;
      DIR_MX:  nx = {2'b00, cx} - 6'd1;
      DIR_PY:  ny = {2'b00, cy} + 6'd1;
      DIR_MY:  ny = {2'b00, cy} - 6'd1;
      DIR_PZ:  nz = {2'b00, cz} + 6'd1;
      DIR_MZ:  nz = {2'b00, cz} - 6'd1;
      default: nx = {2'b00, cx};
    endcase
    nb_ok = !nx[5] && !ny[5] && !nz[5] &&
            (nx[4:0] < ex) && (ny[4:0] < ey) && (nz[4:0] < ez);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR_ALL: if (clr_r == '1) state_nxt = S_IDLE;
      S_CLR_VIS: if (clr_r == '1) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_acc && in_tuser == OP_START) begin
          state_nxt = S_CLR_VIS;
        end else if (in_acc && in_tuser == OP_FETCH) begin
          state_nxt = (head_r >= tail_r) ? S_SCAN_RD : S_POP_RD;
        end
      end
      S_SCAN_RD: state_nxt = sp_r[AW] ? S_EMIT : S_SCAN_CK;
      S_SCAN_CK: state_nxt = (sa_in && hit) ? S_NB_RD : S_SCAN_RD;
      S_POP_RD:  state_nxt = S_POP_WT;
      S_POP_WT:  state_nxt = S_NB_RD;
      S_NB_RD: begin
        if (nb_ok) state_nxt = S_NB_CK;
        else if (dir_r == DIR_MZ) state_nxt = S_EMIT;
      end
      S_NB_CK:   state_nxt = (dir_r == DIR_MZ) ? S_EMIT : S_NB_RD;
      S_EMIT:    if (emit_load) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    creq = '0;
    qreq = '0;
    clr_nxt = clr_r;
    sp_nxt = sp_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt = cnt_r;
    cur_nxt = cur_r;
    sa_nxt = sa_r;
    na_nxt = na_r;
    dir_nxt = dir_r;
    done_nxt = done_r;
    lo_x_nxt = lo_x_r; lo_y_nxt = lo_y_r; lo_z_nxt = lo_z_r;
    hi_x_nxt = hi_x_r; hi_y_nxt = hi_y_r; hi_z_nxt = hi_z_r;
    qreq.rd_addr = head_r[AW-1:0];
    unique case (state_r)
      S_CLR_ALL: begin
        creq.wr_addr = clr_r;
        creq.wr_occ_en = 1'b1;
        creq.wr_vis_en = 1'b1;
        clr_nxt = clr_r + 1'b1;
      end
      S_CLR_VIS: begin
        creq.wr_addr = clr_r;
        creq.wr_vis_en = 1'b1;
        clr_nxt = clr_r + 1'b1;
      end
      S_IDLE: begin
        done_nxt = 1'b0;
        if (in_acc && in_tuser == OP_WRITE) begin
          creq.wr_addr = {wy, wz, wx};
          creq.wr_occ_d = (in_tdata[19:12] != 8'd0);
          creq.wr_occ_en = ({1'b0, wx} < ex) && ({1'b0, wy} < ey) && ({1'b0, wz} < ez);
        end
        if (in_acc && in_tuser == OP_START) begin
          clr_nxt = '0;
          sp_nxt = '0;
          head_nxt = '0;
          tail_nxt = '0;
          cnt_nxt = '0;
          lo_x_nxt = '0; lo_y_nxt = '0; lo_z_nxt = '0;
          hi_x_nxt = '0; hi_y_nxt = '0; hi_z_nxt = '0;
        end
      end
      S_SCAN_RD: begin
        creq.rd_addr = sp_r[AW-1:0];
        if (sp_r[AW]) begin
          done_nxt = 1'b1;
        end else begin
          sa_nxt = sp_r[AW-1:0];
          sp_nxt = sp_r + 1'b1;
        end
      end
      S_SCAN_CK: begin
        if (sa_in && hit) begin
          // seed goes straight to the current voxel, queue slot is skipped
          creq.wr_addr = sa_r;
          creq.wr_vis_en = 1'b1;
          creq.wr_vis_d = 1'b1;
          cur_nxt = sa_r;
          head_nxt = head_r + 1'b1;
          if (!tail_r[AW]) tail_nxt = tail_r + 1'b1;
          lo_x_nxt = sx; lo_y_nxt = sy; lo_z_nxt = sz;
          hi_x_nxt = sx; hi_y_nxt = sy; hi_z_nxt = sz;
          dir_nxt = DIR_PX;
        end
      end
      S_POP_RD: ;
      S_POP_WT: begin
        cur_nxt = q_rd;
        head_nxt = head_r + 1'b1;
        if (qx < lo_x_r) lo_x_nxt = qx;
        if (qy < lo_y_r) lo_y_nxt = qy;
        if (qz < lo_z_r) lo_z_nxt = qz;
        if (qx > hi_x_r) hi_x_nxt = qx;
        if (qy > hi_y_r) hi_y_nxt = qy;
        if (qz > hi_z_r) hi_z_nxt = qz;
        dir_nxt = DIR_PX;
      end
      S_NB_RD: begin
        creq.rd_addr = {ny[CW-1:0], nz[CW-1:0], nx[CW-1:0]};
        na_nxt = {ny[CW-1:0], nz[CW-1:0], nx[CW-1:0]};
        if (!nb_ok && dir_r != DIR_MZ) dir_nxt = dir_t'(dir_r + 3'd1);
      end
      S_NB_CK: begin
        if (hit) begin
          creq.wr_addr = na_r;
          creq.wr_vis_en = 1'b1;
          creq.wr_vis_d = 1'b1;
          if (!tail_r[AW]) begin
            qreq.wr_en = 1'b1;
            qreq.wr_addr = tail_r[AW-1:0];
            qreq.wr_data = na_r;
            tail_nxt = tail_r + 1'b1;
          end
        end
        if (dir_r != DIR_MZ) dir_nxt = dir_t'(dir_r + 3'd1);
      end
      S_EMIT: begin
        if (emit_load && !done_r && head_r >= tail_r) cnt_nxt = cnt_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR_ALL;
      clr_r <= '0;
      sp_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      cnt_r <= '0;
      dir_r <= DIR_PX;
      done_r <= 1'b0;
      lo_x_r <= '0; lo_y_r <= '0; lo_z_r <= '0;
      hi_x_r <= '0; hi_y_r <= '0; hi_z_r <= '0;
      size_x_r <= 5'd16;
      size_y_r <= 5'd16;
      size_z_r <= 5'd16;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      sp_r <= sp_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r <= cnt_nxt;
      dir_r <= dir_nxt;
      done_r <= done_nxt;
      lo_x_r <= lo_x_nxt; lo_y_r <= lo_y_nxt; lo_z_r <= lo_z_nxt;
      hi_x_r <= hi_x_nxt; hi_y_r <= hi_y_nxt; hi_z_r <= hi_z_nxt;
      if (cfg_acc) begin
        unique case (cfg_index)
          CFG_SIZE_X: size_x_r <= cfg_data;
          CFG_SIZE_Y: size_y_r <= cfg_data;
          CFG_SIZE_Z: size_z_r <= cfg_data;
          default: ;
        endcase
      end
      if (emit_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    sa_r <= sa_nxt;
    na_r <= na_nxt;
    if (emit_load) begin
      out_user_r <= done_r;
      out_last_r <= !done_r && (head_r >= tail_r);
      if (done_r) begin
        out_data_r <= '0;
      end else if (head_r >= tail_r) begin
        out_data_r <= {1'b0, hi_z_r, hi_y_r, hi_x_r, lo_z_r, lo_y_r, lo_x_r,
                       cnt_r[10:0], cz, cy, cx};
      end else begin
        out_data_r <= {25'd0, cnt_r[10:0], cz, cy, cx};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  `VIF_ASSERT_NOW(a_head_le_tail, state_r != S_SCAN_CK, head_r <= tail_r)
  `VIF_ASSERT_NOW(a_done_no_last, out_tvalid && out_tuser, !out_tlast)
  `VIF_ASSERT_NOW(a_vis_set_src, creq.wr_vis_en && creq.wr_vis_d,
                  state_r == S_SCAN_CK || state_r == S_NB_CK)
  `VIF_ASSERT_NEXT(a_emit_out, emit_load, out_tvalid && state_r == S_IDLE)
endmodule
`default_nettype wire

[bench/tb_voxel_island_finder_top.sv]
// self-checking bench for voxel_island_finder_top: loads voxel grids, starts flood fills
// and fetches, checking every popped voxel against an in-bench flood fill predictor
// depends on vif_pkg and the voxel_island_finder_top design files
`timescale 1ns / 100ps
`default_nettype none
module tb_voxel_island_finder_top;
  import vif_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct {
    logic [1:0] op;
    logic [3:0] x, y, z;
    logic [7:0] val;
  } cmd_t;

  typedef struct {
    logic [3:0]  x, y, z;
    logic [10:0] island;
    logic        island_end;
    logic [3:0]  min_x, min_y, min_z, max_x, max_y, max_z;
    logic        all_done;
  } voxel_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic out_tlast, out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [4:0] cfg_data = '0;

  voxel_island_finder_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // flood fill predictor state
  logic [4:0] grid_sx = 5'd16, grid_sy = 5'd16, grid_sz = 5'd16;
  bit occ[CELLS];
  bit seen[CELLS];
  int fill_q[CELLS];
  int fill_head, fill_tail, scan_ptr;
  logic [11:0] island_cnt;
  int lo[3], hi[3];

  cmd_t pending_cmds[$];
  voxel_word_t expected_words[$];
  int fail_cnt = 0;
  bit in_quiet = 0, out_quiet = 0;
  int hold_cycles = 0;

  function automatic int axis_extent(logic [4:0] v);
    if (v == 5'd0) return 1;
    if (v > 5'd16) return 16;
    return int'(v);
  endfunction

  function automatic void clear_fill();
    foreach (seen[i]) seen[i] = 0;
    fill_head = 0; fill_tail = 0; scan_ptr = 0; island_cnt = '0;
    for (int k = 0; k < 3; k++) begin lo[k] = 0; hi[k] = 0; end
  endfunction

  function automatic void predict_cmd(cmd_t c);
    int sx, sy, sz, a, x, y, z, nx, ny, nz, na;
    int v[3];
    int dx[6] = '{1, -1, 0, 0, 0, 0};
    int dy[6] = '{0, 0, 1, -1, 0, 0};
    int dz[6] = '{0, 0, 0, 0, 1, -1};
    bit found;
    voxel_word_t r;
    sx = axis_extent(grid_sx); sy = axis_extent(grid_sy); sz = axis_extent(grid_sz);
    if (c.op == OP_WRITE) begin
      if (c.x < sx && c.y < sy && c.z < sz)
        occ[{c.y, c.z, c.x}] = (c.val != 0);
      return;
    end
    if (c.op == OP_START) begin
      clear_fill();
      return;
    end
    if (c.op != OP_FETCH) return;
    r = '{default: '0};
    if (fill_head >= fill_tail) begin
      found = 0;
      while (!found && scan_ptr < CELLS) begin
        a = scan_ptr;
        x = a % 16; z = (a / 16) % 16; y = a / 256;
        scan_ptr++;
        if (x < sx && y < sy && z < sz && occ[a] && !seen[a]) begin
          seen[a] = 1;
          fill_q[fill_tail++] = a;
          lo[0] = x; hi[0] = x; lo[1] = y; hi[1] = y; lo[2] = z; hi[2] = z;
          found = 1;
        end
      end
      if (!found) begin
        r.all_done = 1'b1;
        expected_words.insert(expected_words.size(), r);
        return;
      end
    end
    a = fill_q[fill_head++];
    x = a % 16; z = (a / 16) % 16; y = a / 256;
    v[0] = x; v[1] = y; v[2] = z;
    for (int k = 0; k < 3; k++) begin
      if (v[k] < lo[k]) lo[k] = v[k];
      if (v[k] > hi[k]) hi[k] = v[k];
    end
    for (int i = 0; i < 6; i++) begin
      nx = x + dx[i]; ny = y + dy[i]; nz = z + dz[i];
      if (nx >= 0 && nx < sx && ny >= 0 && ny < sy && nz >= 0 && nz < sz) begin
        na = nx + nz * 16 + ny * 256;
        if (!seen[na] && occ[na]) begin
          seen[na] = 1;
          if (fill_tail < CELLS) fill_q[fill_tail++] = na;
        end
      end
    end
    r.x = 4'(x); r.y = 4'(y); r.z = 4'(z);
    r.island = island_cnt[10:0];
    if (fill_head >= fill_tail) begin
      r.island_end = 1'b1;
      r.min_x = 4'(lo[0]); r.min_y = 4'(lo[1]); r.min_z = 4'(lo[2]);
      r.max_x = 4'(hi[0]); r.max_y = 4'(hi[1]); r.max_z = 4'(hi[2]);
      island_cnt = island_cnt + 12'd1;
    end
    expected_words.insert(expected_words.size(), r);
  endfunction

  // input driver
  cmd_t cur_cmd;
  bit in_taken = 0;
  int in_gap = 0;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      predict_cmd(cur_cmd);
      in_taken <= 1'b1;
    end
  end

  always @(negedge clk) begin
    logic nv;
    nv = in_tvalid;
    if (in_taken) begin
      nv = 1'b0;
      in_taken <= 1'b0;
    end
    if (rst_n && !nv) begin
      if (in_gap > 0) in_gap--;
      else if (pending_cmds.size() > 0) begin
        cur_cmd = pending_cmds.pop_front();
        in_tdata <= {4'b0, cur_cmd.val, cur_cmd.z, cur_cmd.y, cur_cmd.x};
        in_tuser <= cur_cmd.op;
        nv = 1'b1;
        in_gap = in_quiet ? 0 : $urandom_range(0, 4);
      end
    end
    in_tvalid <= nv;
  end

  // result monitor
  int out_gap = 0;

  always @(negedge clk) begin
    if (hold_cycles > 0) hold_cycles--;
  end

  always @(negedge clk) begin
    if (!rst_n || hold_cycles > 0) out_tready <= 1'b0;
    else if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else out_tready <= 1'b1;
  end

  always @(posedge clk) begin
    voxel_word_t e, g;
    if (rst_n && out_tvalid && out_tready) begin
      out_gap = out_quiet ? 0 : $urandom_range(0, 4);
      g.x = out_tdata[3:0]; g.y = out_tdata[7:4]; g.z = out_tdata[11:8];
      g.island = out_tdata[22:12];
      g.min_x = out_tdata[26:23]; g.min_y = out_tdata[30:27]; g.min_z = out_tdata[34:31];
      g.max_x = out_tdata[38:35]; g.max_y = out_tdata[42:39]; g.max_z = out_tdata[46:43];
      g.island_end = out_tlast; g.all_done = out_tuser;
      if (expected_words.size() == 0) begin
        $display("%0t unexpected word: tdata %h tlast %b tuser %b", $time, out_tdata,
                 out_tlast, out_tuser);
        fail_cnt++;
      end else begin
        e = expected_words.pop_front();
        if (g.x != e.x) begin $display("%0t x exp %0d got %0d", $time, e.x, g.x); fail_cnt++; end
        if (g.y != e.y) begin $display("%0t y exp %0d got %0d", $time, e.y, g.y); fail_cnt++; end
        if (g.z != e.z) begin $display("%0t z exp %0d got %0d", $time, e.z, g.z); fail_cnt++; end
        if (g.island != e.island) begin
          $display("%0t island exp %0d got %0d", $time, e.island, g.island); fail_cnt++;
        end
        if (g.island_end != e.island_end) begin
          $display("%0t island_end exp %b got %b", $time, e.island_end, g.island_end);
          fail_cnt++;
        end
        if (g.all_done != e.all_done) begin
          $display("%0t all_done exp %b got %b", $time, e.all_done, g.all_done); fail_cnt++;
        end
        if ({g.min_x, g.min_y, g.min_z} != {e.min_x, e.min_y, e.min_z}) begin
          $display("%0t min xyz exp %h got %h", $time, {e.min_x, e.min_y, e.min_z},
                   {g.min_x, g.min_y, g.min_z});
          fail_cnt++;
        end
        if ({g.max_x, g.max_y, g.max_z} != {e.max_x, e.max_y, e.max_z}) begin
          $display("%0t max xyz exp %h got %h", $time, {e.max_x, e.max_y, e.max_z},
                   {g.max_x, g.max_y, g.max_z});
          fail_cnt++;
        end
      end
    end
  end

  // stimulus
  int queued_total = 0;

  task automatic add_cmd(logic [1:0] op, int x, int y, int z, int val);
    cmd_t c;
    c.op = op; c.x = 4'(x); c.y = 4'(y); c.z = 4'(z); c.val = 8'(val);
    pending_cmds.insert(pending_cmds.size(), c);
    queued_total++;
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || in_tvalid || expected_words.size() > 0)
      @(posedge clk);
    // a start may still be sweeping the visited marks
    repeat (4300) @(posedge clk);
  endtask

  task automatic write_size(logic [1:0] idx, logic [4:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SIZE_X: grid_sx = val;
      CFG_SIZE_Y: grid_sy = val;
      default:    grid_sz = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [4:0] pick_size();
    case ($urandom_range(0, 7))
      0: return 5'd0;
      1: return 5'd31;
      2: return 5'd16;
      3: return 5'($urandom_range(0, 31));
      default: return 5'($urandom_range(1, 5));
    endcase
  endfunction

  task automatic blob_phase();
    int sx, sy, sz, x, y, z, nw, nf, r;
    sx = axis_extent(grid_sx); sy = axis_extent(grid_sy); sz = axis_extent(grid_sz);
    nw = $urandom_range(15, 35);
    x = $urandom_range(0, sx - 1); y = $urandom_range(0, sy - 1); z = $urandom_range(0, sz - 1);
    for (int i = 0; i < nw; i++) begin
      r = $urandom_range(0, 9);
      if (r == 0)
        add_cmd(OP_WRITE, $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                $urandom_range(0, 255));
      else begin
        // random walk keeps most writes touching so islands grow
        case ($urandom_range(0, 2))
          0: x = (x + $urandom_range(0, 2) + sx - 1) % sx;
          1: y = (y + $urandom_range(0, 2) + sy - 1) % sy;
          default: z = (z + $urandom_range(0, 2) + sz - 1) % sz;
        endcase
        add_cmd(OP_WRITE, x, y, z, (r < 8) ? $urandom_range(1, 255) : 0);
      end
    end
    add_cmd(OP_START, $urandom_range(0, 15), 0, 0, $urandom_range(0, 255));
    nf = nw + $urandom_range(2, 6);
    for (int i = 0; i < nf; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0) add_cmd(OP_SPARE, $urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 15), $urandom_range(0, 255));
      else if (r == 1) add_cmd(OP_WRITE, $urandom_range(0, sx - 1), $urandom_range(0, sy - 1),
                               $urandom_range(0, sz - 1), $urandom_range(0, 255));
      else if (r == 2 && i > nf / 2) add_cmd(OP_START, 0, 0, 0, 0);
      add_cmd(OP_FETCH, $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
              $urandom_range(0, 255));
    end
  endtask

  initial begin
    int phase;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    occ = '{default: 0};
    clear_fill();

    // directed: fetch before start, corners, zero clears, ignored opcode
    add_cmd(OP_FETCH, 0, 0, 0, 0);
    add_cmd(OP_WRITE, 0, 0, 0, 1);
    add_cmd(OP_WRITE, 1, 0, 0, 255);
    add_cmd(OP_WRITE, 0, 1, 0, 7);
    add_cmd(OP_WRITE, 0, 0, 1, 3);
    add_cmd(OP_WRITE, 15, 15, 15, 128);
    add_cmd(OP_WRITE, 5, 5, 5, 9);
    add_cmd(OP_WRITE, 5, 5, 5, 0);
    add_cmd(OP_SPARE, 15, 15, 15, 255);
    add_cmd(OP_START, 0, 0, 0, 0);
    repeat (7) add_cmd(OP_FETCH, 0, 0, 0, 0);
    add_cmd(OP_WRITE, 15, 15, 15, 0);
    add_cmd(OP_START, 0, 0, 0, 0);
    repeat (6) add_cmd(OP_FETCH, 15, 15, 15, 255);
    wait_drained();

    // sizes at the extremes, write outside the size is dropped
    write_size(CFG_SIZE_X, 5'd0);
    write_size(CFG_SIZE_Y, 5'd31);
    write_size(CFG_SIZE_Z, 5'd1);
    add_cmd(OP_WRITE, 1, 3, 0, 4);
    add_cmd(OP_WRITE, 0, 3, 0, 4);
    add_cmd(OP_START, 0, 0, 0, 0);
    repeat (5) add_cmd(OP_FETCH, 0, 0, 0, 0);
    wait_drained();

    phase = 0;
    while (queued_total < 1150) begin
      write_size(CFG_SIZE_X, pick_size());
      write_size(CFG_SIZE_Y, pick_size());
      write_size(CFG_SIZE_Z, pick_size());
      in_quiet = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      blob_phase();
      if (phase == 2) hold_cycles = 600;
      wait_drained();
      phase++;
    end
    repeat (50) @(posedge clk);
    if (fail_cnt == 0 && expected_words.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #500ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire
